// File: sv/dbrf_pkg.sv
`timescale 1ns / 1ps
package dbrf_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 8;
  localparam int CAP_W     = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] EMPTY_MARK = 8'hEE;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_FORCE = 2'd1,
    OP_POP   = 2'd2,
    OP_LIST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NOEL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CK,
    S_WRITE,
    S_EMIT_OK,
    S_EMIT_FULL,
    S_EMIT_NOEL,
    S_POP_RD,
    S_POP_WR,
    S_EMIT_POP,
    S_LIST_RD,
    S_LIST_CK,
    S_LIST_END
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    inc_idx;
    logic    rd_en;
    logic    rd_tail;
    logic    wr_en;
    logic    wr_pop;
    logic    adv_head;
    logic    adv_tail;
    logic    pend_load;
    logic    out_load;
    status_e out_status;
    logic    out_elem;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic scan_done;
    logic match;
    logic elem;
    logic pend_vld;
    logic out_free;
  } sts_t;

endpackage

// File: sv/dbrf_ram.sv
`timescale 1ns / 1ps
module dbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dbrf_ctrl.sv
`timescale 1ns / 1ps
module dbrf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dbrf_pkg::sts_t sts_i,
  output dbrf_pkg::cmd_t cmd_o
);

  dbrf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbrf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dbrf_pkg::S_IDLE: begin
        if (in_valid_i) state_d = dbrf_pkg::S_DISPATCH;
      end
      dbrf_pkg::S_DISPATCH: begin
        case (sts_i.op)
          dbrf_pkg::OP_PUSH:  state_d = sts_i.full ? dbrf_pkg::S_EMIT_FULL : dbrf_pkg::S_SCAN_RD;
          dbrf_pkg::OP_FORCE: state_d = sts_i.full ? dbrf_pkg::S_EMIT_FULL : dbrf_pkg::S_WRITE;
          dbrf_pkg::OP_POP:   state_d = sts_i.empty ? dbrf_pkg::S_EMIT_NOEL : dbrf_pkg::S_POP_RD;
          default:            state_d = dbrf_pkg::S_LIST_RD;
        endcase
      end
      dbrf_pkg::S_SCAN_RD: begin
        state_d = sts_i.scan_done ? dbrf_pkg::S_WRITE : dbrf_pkg::S_SCAN_CK;
      end
      dbrf_pkg::S_SCAN_CK: begin
        state_d = sts_i.match ? dbrf_pkg::S_EMIT_OK : dbrf_pkg::S_SCAN_RD;
      end
      dbrf_pkg::S_WRITE:  state_d = dbrf_pkg::S_EMIT_OK;
      dbrf_pkg::S_POP_RD: state_d = dbrf_pkg::S_POP_WR;
      dbrf_pkg::S_POP_WR: state_d = dbrf_pkg::S_EMIT_POP;
      dbrf_pkg::S_EMIT_OK, dbrf_pkg::S_EMIT_FULL, dbrf_pkg::S_EMIT_NOEL,
      dbrf_pkg::S_EMIT_POP, dbrf_pkg::S_LIST_END: begin
        if (sts_i.out_free) state_d = dbrf_pkg::S_IDLE;
      end
      dbrf_pkg::S_LIST_RD: begin
        state_d = sts_i.scan_done ? dbrf_pkg::S_LIST_END : dbrf_pkg::S_LIST_CK;
      end
      dbrf_pkg::S_LIST_CK: begin
        if (!sts_i.elem || !sts_i.pend_vld || sts_i.out_free) state_d = dbrf_pkg::S_LIST_RD;
      end
      default: state_d = dbrf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = dbrf_pkg::ST_OK;
    in_stall_o       = (state_q != dbrf_pkg::S_IDLE);
    case (state_q)
      dbrf_pkg::S_IDLE: begin
        cmd_o.capture = in_valid_i;
      end
      dbrf_pkg::S_SCAN_RD, dbrf_pkg::S_LIST_RD: begin
        cmd_o.rd_en = !sts_i.scan_done;
      end
      dbrf_pkg::S_SCAN_CK: begin
        cmd_o.inc_idx = !sts_i.match;
      end
      dbrf_pkg::S_WRITE: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.adv_head = 1'b1;
      end
      dbrf_pkg::S_POP_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_tail = 1'b1;
      end
      dbrf_pkg::S_POP_WR: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_pop    = 1'b1;
        cmd_o.adv_tail  = 1'b1;
        cmd_o.pend_load = 1'b1;
      end
      dbrf_pkg::S_EMIT_OK: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = 1'b1;
      end
      dbrf_pkg::S_EMIT_FULL: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_status = dbrf_pkg::ST_FULL;
        cmd_o.out_last   = 1'b1;
      end
      dbrf_pkg::S_EMIT_NOEL: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_status = dbrf_pkg::ST_NOEL;
        cmd_o.out_last   = 1'b1;
      end
      dbrf_pkg::S_EMIT_POP: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_elem = 1'b1;
        cmd_o.out_last = 1'b1;
      end
      dbrf_pkg::S_LIST_CK: begin
        if (!sts_i.elem) begin
          cmd_o.inc_idx = 1'b1;
        end else if (!sts_i.pend_vld || sts_i.out_free) begin
          cmd_o.inc_idx   = 1'b1;
          cmd_o.pend_load = 1'b1;
          cmd_o.out_load  = sts_i.pend_vld;
          cmd_o.out_elem  = 1'b1;
        end
      end
      dbrf_pkg::S_LIST_END: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_elem = sts_i.pend_vld;
        cmd_o.out_last = 1'b1;
      end
      default: begin
        cmd_o.out_status = dbrf_pkg::ST_OK;
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending beat");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !cmd_o.rd_en)
    else $error("slot read and write in one cycle");

  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == dbrf_pkg::S_DISPATCH)
    else $error("captured beat not dispatched");

endmodule

// File: sv/dbrf_dp.sv
`timescale 1ns / 1ps
module dbrf_dp #(
  parameter int DEPTH = dbrf_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    opcode_i,
  input  logic [dbrf_pkg::DATA_W-1:0]   data_i,
  input  logic                          cfg_we_i,
  input  logic [dbrf_pkg::CAP_W-1:0]    cfg_capacity_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [dbrf_pkg::DATA_W-1:0]   data_out_o,
  output logic                          element_valid_o,
  output logic                          last_o,
  output logic                          not_empty_o,
  input  dbrf_pkg::cmd_t                cmd_i,
  output dbrf_pkg::sts_t                sts_o
);

  localparam int PW  = $clog2(DEPTH);
  localparam int SW  = $clog2(DEPTH + 1);
  localparam int MW  = (SW > dbrf_pkg::CAP_W) ? SW : dbrf_pkg::CAP_W;
  localparam int DW  = dbrf_pkg::DATA_W;

  logic [dbrf_pkg::CAP_W-1:0] cap_q;
  logic [PW-1:0]              head_q, tail_q;
  logic [SW-1:0]              idx_q;
  dbrf_pkg::op_e              op_q;
  logic [DW-1:0]              data_q;
  logic [DW-1:0]              pend_q;
  logic                       pend_vld_q;
  logic [DEPTH-1:0]           vld_q;
  logic                       rvld_q;
  logic                       out_valid_q;
  dbrf_pkg::status_e          out_status_q;
  logic [DW-1:0]              out_data_q;
  logic                       out_ev_q, out_last_q, out_ne_q;

  logic [MW-1:0] cap_ext, span, head_inc, tail_inc;
  logic [PW-1:0] head_adv, tail_adv, raddr, waddr;
  logic [DW-1:0] rdata, wdata, eff;
  logic          out_free;

  assign cap_ext  = MW'(cap_q);
  assign span     = (cap_ext > MW'(DEPTH)) ? MW'(DEPTH) : cap_ext;
  assign head_inc = MW'(head_q) + MW'(1);
  assign tail_inc = MW'(tail_q) + MW'(1);
  assign head_adv = (head_inc >= span) ? '0 : head_inc[PW-1:0];
  assign tail_adv = (tail_inc >= span) ? '0 : tail_inc[PW-1:0];

  assign raddr = cmd_i.rd_tail ? tail_q : idx_q[PW-1:0];
  assign waddr = cmd_i.wr_pop ? tail_q : head_q;
  assign wdata = cmd_i.wr_pop ? dbrf_pkg::EMPTY_MARK : data_q;
  assign eff   = rvld_q ? rdata : dbrf_pkg::EMPTY_MARK;

  assign out_free = !out_valid_q || !out_stall_i;

  dbrf_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= dbrf_pkg::CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      idx_q       <= '0;
      pend_vld_q  <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= dbrf_pkg::OP_PUSH;
    end else begin
      if (cfg_we_i) cap_q <= cfg_capacity_i;
      if (cmd_i.capture) begin
        op_q       <= dbrf_pkg::op_e'(opcode_i);
        idx_q      <= '0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.inc_idx) idx_q <= idx_q + SW'(1);
      if (cmd_i.adv_head) head_q <= head_adv;
      if (cmd_i.adv_tail) tail_q <= tail_adv;
      if (cmd_i.wr_en) vld_q[waddr] <= 1'b1;
      if (cmd_i.pend_load) pend_vld_q <= 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) data_q <= data_i;
    if (cmd_i.rd_en) rvld_q <= vld_q[raddr];
    if (cmd_i.pend_load) pend_q <= eff;
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_data_q   <= cmd_i.out_elem ? pend_q : '0;
      out_ev_q     <= cmd_i.out_elem;
      out_last_q   <= cmd_i.out_last;
      out_ne_q     <= (head_q != tail_q);
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.full      = (head_adv == tail_q);
    sts_o.empty     = (head_q == tail_q);
    sts_o.scan_done = (MW'(idx_q) >= span);
    sts_o.match     = (eff == data_q);
    sts_o.elem      = (eff != dbrf_pkg::EMPTY_MARK);
    sts_o.pend_vld  = pend_vld_q;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign data_out_o      = out_data_q;
  assign element_valid_o = out_ev_q;
  assign last_o          = out_last_q;
  assign not_empty_o     = out_ne_q;

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(head_q) < MW'(DEPTH))
    else $error("head pointer beyond depth");

  a_tail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(tail_q) < MW'(DEPTH))
    else $error("tail pointer beyond depth");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.adv_tail |=> vld_q[$past(tail_q)])
    else $error("popped slot not marked written");

endmodule

// File: sv/dedup_byte_ring_fifo_core.sv
`timescale 1ns / 1ps
// Byte ring FIFO with duplicate filtering; one slot always stays free, so at most
// min(capacity, DEPTH)-1 bytes are held. Items are handled one at a time: input
// stall is high from the accepted beat until the last result is loaded into the
// output register. A checked push compares each slot below min(capacity, DEPTH) in
// turn, stops at a duplicate and writes only if none was found; a forced push writes
// without a scan; pop reads the tail slot, then clears it; a push to a full buffer or
// a pop from an empty one only emits its status; list reads each slot in turn and
// emits every one not reading as 0xEE. The scan speed is set by the single read port
// of the slot RAM and its registered read data. Slots never written read as 0xEE. The
// capacity register is accepted only while no item is in flight.
module dedup_byte_ring_fifo_core #(
  parameter int DEPTH = dbrf_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [dbrf_pkg::DATA_W-1:0] data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [dbrf_pkg::DATA_W-1:0] data_out_o,
  output logic                        element_valid_o,
  output logic                        last_o,
  output logic                        not_empty_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dbrf_pkg::CAP_W-1:0]  cfg_capacity_i
);

  dbrf_pkg::cmd_t cmd;
  dbrf_pkg::sts_t sts;

  assign cfg_ready_o = !in_stall_o;

  dbrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dbrf_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .data_i         (data_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .element_valid_o(element_valid_o),
    .last_o         (last_o),
    .not_empty_o    (not_empty_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE = 2 * dbrf_pkg::DEPTH_DEF + 8;
  localparam int RANDOM_ITEMS = 325;

  typedef struct packed {
    dbrf_pkg::status_e           status;
    logic [dbrf_pkg::DATA_W-1:0] data;
    logic                        elem;
    logic                        last;
    logic                        not_empty;
  } fifo_beat_t;

  class fifo_shadow;
    logic [dbrf_pkg::DATA_W-1:0] slots [dbrf_pkg::DEPTH_DEF];
    logic [3:0]                  head;
    logic [3:0]                  tail;
    logic [dbrf_pkg::CAP_W-1:0]  capacity;
    fifo_beat_t                  due_beats [$];
    int                          errors;

    function new();
      foreach (slots[i]) slots[i] = dbrf_pkg::EMPTY_MARK;
      head = '0;
      tail = '0;
      capacity = dbrf_pkg::CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [dbrf_pkg::CAP_W-1:0] c);
      capacity = c;
    endfunction

    function logic [4:0] span();
      return (capacity > dbrf_pkg::DEPTH_DEF) ? 5'(dbrf_pkg::DEPTH_DEF) : capacity;
    endfunction

    function logic [3:0] wrap_next(logic [3:0] p);
      logic [4:0] n;
      n = {1'b0, p} + 5'd1;
      return (n >= span()) ? 4'd0 : n[3:0];
    endfunction

    function bit holds(logic [dbrf_pkg::DATA_W-1:0] v);
      for (int i = 0; i < span(); i++) begin
        if (slots[i] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function fifo_beat_t beat(dbrf_pkg::status_e st, logic [dbrf_pkg::DATA_W-1:0] d,
                              logic ev, logic lst);
      fifo_beat_t b;
      b.status = st;
      b.data = d;
      b.elem = ev;
      b.last = lst;
      b.not_empty = (head != tail);
      return b;
    endfunction

    function void take_command(dbrf_pkg::op_e op, logic [dbrf_pkg::DATA_W-1:0] d);
      logic [3:0]                  nxt;
      logic [dbrf_pkg::DATA_W-1:0] v;
      fifo_beat_t                  listed [$];
      case (op)
        dbrf_pkg::OP_PUSH, dbrf_pkg::OP_FORCE: begin
          nxt = wrap_next(head);
          if (nxt == tail) begin
            due_beats.push_back(beat(dbrf_pkg::ST_FULL, '0, 1'b0, 1'b1));
          end else begin
            if (op == dbrf_pkg::OP_FORCE || !holds(d)) begin
              slots[head] = d;
              head = nxt;
            end
            due_beats.push_back(beat(dbrf_pkg::ST_OK, '0, 1'b0, 1'b1));
          end
        end
        dbrf_pkg::OP_POP: begin
          if (head == tail) begin
            due_beats.push_back(beat(dbrf_pkg::ST_NOEL, '0, 1'b0, 1'b1));
          end else begin
            v = slots[tail];
            slots[tail] = dbrf_pkg::EMPTY_MARK;
            tail = wrap_next(tail);
            due_beats.push_back(beat(dbrf_pkg::ST_OK, v, 1'b1, 1'b1));
          end
        end
        default: begin
          for (int i = 0; i < span(); i++) begin
            if (slots[i] != dbrf_pkg::EMPTY_MARK)
              listed.push_back(beat(dbrf_pkg::ST_OK, slots[i], 1'b1, 1'b0));
          end
          if (listed.size() == 0) begin
            due_beats.push_back(beat(dbrf_pkg::ST_OK, '0, 1'b0, 1'b1));
          end else begin
            listed[listed.size()-1].last = 1'b1;
            foreach (listed[i]) due_beats.push_back(listed[i]);
          end
        end
      endcase
    endfunction

    function void check_beat(fifo_beat_t got);
      fifo_beat_t want;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: status=%0d data=%02h elem=%0b last=%0b ne=%0b",
                   got.status, got.data, got.elem, got.last, got.not_empty);
        return;
      end
      want = due_beats.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp status=%0d data=%02h elem=%0b last=%0b ne=%0b,",
                   want.status, want.data, want.elem, want.last, want.not_empty);
          $display("          got status=%0d data=%02h elem=%0b last=%0b ne=%0b",
                   got.status, got.data, got.elem, got.last, got.not_empty);
        end
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  opcode_i = dbrf_pkg::OP_PUSH;
  logic [dbrf_pkg::DATA_W-1:0] data_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [1:0]                  status_o;
  logic [dbrf_pkg::DATA_W-1:0] data_out_o;
  logic                        element_valid_o;
  logic                        last_o;
  logic                        not_empty_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [dbrf_pkg::CAP_W-1:0]  cfg_capacity_i = dbrf_pkg::CAP_RESET;

  fifo_shadow shadow = new();
  fifo_beat_t seen;
  int quiet_cycles = 0;
  int stall_max = 0;
  int stall_run = 0;
  int gap_max = 0;
  int burst_left = 0;
  int push_pct = 50;
  int issued = 0;

  dedup_byte_ring_fifo_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .data_i          (data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .data_out_o      (data_out_o),
    .element_valid_o (element_valid_o),
    .last_o          (last_o),
    .not_empty_o     (not_empty_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_capacity_i  (cfg_capacity_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      out_stall_i = (stall_max != 0) && !out_stall_i;
      stall_run = out_stall_i ? $urandom_range(1, stall_max) : $urandom_range(1, 10);
    end
    stall_run--;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) shadow.set_capacity(cfg_capacity_i);
      if (in_valid_i && !in_stall_o)
        shadow.take_command(dbrf_pkg::op_e'(opcode_i), data_i);
      if (out_valid_o && !out_stall_i) begin
        seen.status = dbrf_pkg::status_e'(status_o);
        seen.data = data_out_o;
        seen.elem = element_valid_o;
        seen.last = last_o;
        seen.not_empty = not_empty_o;
        shadow.check_beat(seen);
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(dbrf_pkg::op_e op, logic [dbrf_pkg::DATA_W-1:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
    end
    burst_left--;
    opcode_i = op;
    data_i = d;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    issued++;
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int                          r;
    dbrf_pkg::op_e               op;
    logic [dbrf_pkg::DATA_W-1:0] d;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      op = ($urandom_range(0, 3) == 0) ? dbrf_pkg::OP_FORCE : dbrf_pkg::OP_PUSH;
    else if (r < push_pct + (100 - push_pct) * 2 / 3) op = dbrf_pkg::OP_POP;
    else op = dbrf_pkg::OP_LIST;
    r = $urandom_range(0, 99);
    if (r < 45) d = dbrf_pkg::DATA_W'($urandom_range(0, 7));
    else if (r < 52) d = dbrf_pkg::EMPTY_MARK;
    else d = dbrf_pkg::DATA_W'($urandom_range(0, 255));
    send(op, d);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (shadow.due_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [dbrf_pkg::CAP_W-1:0] c);
    drain();
    cfg_capacity_i = c;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [dbrf_pkg::CAP_W-1:0] caps [7];
    int phase;
    int phase_len;
    caps = '{5'd31, 5'd16, 5'd2, 5'd0, 5'd1, 5'd16, 5'd2};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(dbrf_pkg::OP_LIST, 8'h00);
    send(dbrf_pkg::OP_POP, 8'h00);
    send(dbrf_pkg::OP_PUSH, 8'h00);
    send(dbrf_pkg::OP_PUSH, 8'hFF);
    send(dbrf_pkg::OP_PUSH, 8'h00);
    send(dbrf_pkg::OP_PUSH, dbrf_pkg::EMPTY_MARK);
    send(dbrf_pkg::OP_FORCE, dbrf_pkg::EMPTY_MARK);
    send(dbrf_pkg::OP_FORCE, 8'h00);
    send(dbrf_pkg::OP_LIST, 8'hFF);
    repeat (5) send(dbrf_pkg::OP_POP, 8'hFF);

    write_capacity(5'd2);
    send(dbrf_pkg::OP_PUSH, 8'h12);
    send(dbrf_pkg::OP_PUSH, 8'h34);
    send(dbrf_pkg::OP_FORCE, 8'h56);
    send(dbrf_pkg::OP_LIST, 8'h00);
    send(dbrf_pkg::OP_POP, 8'h00);
    send(dbrf_pkg::OP_POP, 8'h00);

    write_capacity(5'd1);
    send(dbrf_pkg::OP_PUSH, 8'hA5);
    send(dbrf_pkg::OP_LIST, 8'h00);
    send(dbrf_pkg::OP_POP, 8'h00);

    write_capacity(5'd0);
    send(dbrf_pkg::OP_PUSH, 8'h5A);
    send(dbrf_pkg::OP_LIST, 8'h00);

    issued = 0;
    phase = 0;
    while (issued < RANDOM_ITEMS) begin
      write_capacity((phase < 7) ? caps[phase] :
                     dbrf_pkg::CAP_W'($urandom_range(2, 16)));
      case ($urandom_range(0, 2))
        0: stall_max = 0;
        1: stall_max = 3;
        default: stall_max = 12;
      endcase
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 4;
        default: gap_max = 20;
      endcase
      push_pct = $urandom_range(30, 75);
      phase_len = $urandom_range(20, 45);
      repeat (phase_len) begin
        if (issued < RANDOM_ITEMS) send_random();
      end
      phase++;
    end

    drain();
    if (shadow.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dbrf_pkg.sv
sv/dbrf_ram.sv
sv/dbrf_ctrl.sv
sv/dbrf_dp.sv
sv/dedup_byte_ring_fifo_core.sv
verif/testbench.sv
